// File: rtl/crc16_packet_framer_macros.svh
// Assertion macros for the framer; each use names the clock and reset of the including module.
`ifndef CRC16_PACKET_FRAMER_MACROS_SVH
`define CRC16_PACKET_FRAMER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define CPF_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define CPF_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: rtl/cpf_pkg.sv
package cpf_pkg;

	localparam int unsigned QueueDepthDefault = 4;
	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;

	typedef enum logic [2:0] {
		REG_START_MARKER   = 3'd0,
		REG_END_MARKER     = 3'd1,
		REG_FRAME_TYPE     = 3'd2,
		REG_PAYLOAD_LENGTH = 3'd3,
		REG_CRC_POLYNOMIAL = 3'd4,
		REG_CRC_INITIAL    = 3'd5
	} reg_idx_t;

	localparam logic [7:0]  StartMarkerReset   = 8'h7e;
	localparam logic [7:0]  EndMarkerReset     = 8'h7f;
	localparam logic [7:0]  FrameTypeReset     = 8'h02;
	localparam logic [7:0]  PayloadLengthReset = 8'd69;
	localparam logic [15:0] CrcPolynomialReset = 16'ha001;
	localparam logic [15:0] CrcInitialReset    = 16'h0000;

	typedef struct packed {
		logic [7:0]  start_marker;
		logic [7:0]  end_marker;
		logic [7:0]  frame_type;
		logic [7:0]  payload_length;
		logic [15:0] crc_polynomial;
		logic [15:0] crc_initial;
	} cfg_t;

	// one classified payload byte, handed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        closing;
		logic [15:0] crc;
	} ent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [6:0] {
		SL_START  = 7'b0000001,
		SL_TYPE   = 7'b0000010,
		SL_LEN    = 7'b0000100,
		SL_DATA   = 7'b0001000,
		SL_CRC_HI = 7'b0010000,
		SL_CRC_LO = 7'b0100000,
		SL_END    = 7'b1000000
	} slot_t;

	function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/cpf_regs.sv
module cpf_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cpf_pkg::AddrWidth-1:0]       paddr,
	input  logic [cpf_pkg::DataWidth-1:0]       pwdata,
	output logic [cpf_pkg::DataWidth-1:0]       prdata,
	output logic                                pready,
	output cpf_pkg::cfg_t                       cfg
);
	import cpf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker   <= StartMarkerReset;
			cfg_q.end_marker     <= EndMarkerReset;
			cfg_q.frame_type     <= FrameTypeReset;
			cfg_q.payload_length <= PayloadLengthReset;
			cfg_q.crc_polynomial <= CrcPolynomialReset;
			cfg_q.crc_initial    <= CrcInitialReset;
		end else if (wr) begin
			unique case (idx)
				REG_START_MARKER:   cfg_q.start_marker   <= pwdata[7:0];
				REG_END_MARKER:     cfg_q.end_marker     <= pwdata[7:0];
				REG_FRAME_TYPE:     cfg_q.frame_type     <= pwdata[7:0];
				REG_PAYLOAD_LENGTH: cfg_q.payload_length <= pwdata[7:0];
				REG_CRC_POLYNOMIAL: cfg_q.crc_polynomial <= pwdata[15:0];
				REG_CRC_INITIAL:    cfg_q.crc_initial    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_START_MARKER:   prdata = {24'h0, cfg_q.start_marker};
			REG_END_MARKER:     prdata = {24'h0, cfg_q.end_marker};
			REG_FRAME_TYPE:     prdata = {24'h0, cfg_q.frame_type};
			REG_PAYLOAD_LENGTH: prdata = {24'h0, cfg_q.payload_length};
			REG_CRC_POLYNOMIAL: prdata = {16'h0, cfg_q.crc_polynomial};
			REG_CRC_INITIAL:    prdata = {16'h0, cfg_q.crc_initial};
			default:            prdata = '0;
		endcase
	end

endmodule

// File: rtl/cpf_front.sv
module cpf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  cpf_pkg::cfg_t cfg,
	input  logic          accept,
	input  logic [7:0]    payload_byte,
	output cpf_pkg::ent_t ent
);
	import cpf_pkg::*;

	logic [7:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  next_pos;
	logic [15:0] base;
	logic [15:0] folded;
	logic        first;
	logic        closing;

	assign first    = (pos_q == 8'd0);
	assign base     = first ? cfg.crc_initial : crc_q;
	assign folded   = fold_byte(base, payload_byte, cfg.crc_polynomial);
	assign next_pos = pos_q + 8'd1;
	// length 0 closes after 256 bytes through the wrap
	assign closing  = (next_pos == cfg.payload_length);

	assign ent.data    = payload_byte;
	assign ent.first   = first;
	assign ent.closing = closing;
	assign ent.crc     = folded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'd0;
			crc_q <= 16'h0000;
		end else if (accept) begin
			pos_q <= closing ? 8'd0 : next_pos;
			crc_q <= folded;
		end
	end

endmodule

// File: rtl/cpf_fifo.sv
module cpf_fifo #(
	parameter int unsigned DEPTH = cpf_pkg::QueueDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  cpf_pkg::ent_t   wdata,
	input  logic            rd,
	output cpf_pkg::ent_t   rdata,
	output cpf_pkg::q_stat_t stat
);
	import cpf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] Full    = CW'(DEPTH);

	ent_t          slot_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == Full);
	assign stat.empty = (cnt_q == '0);
	assign rdata      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == LastIdx) ? '0 : wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == LastIdx) ? '0 : rp_q + AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/cpf_back.sv
module cpf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cpf_pkg::cfg_t    cfg,
	input  cpf_pkg::ent_t    head,
	input  cpf_pkg::q_stat_t qstat,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       frame_byte,
	output logic             run_last,
	output logic             frame_end
);
	import cpf_pkg::*;

	slot_t      step_q;
	logic       started_q;
	logic       oval_q;
	logic [7:0] obyte_q;
	logic       olast_q;
	logic       oend_q;

	slot_t      cur;
	slot_t      nxt;
	logic       load;
	logic       emit;
	logic       last;
	logic [7:0] byte_d;

	assign cur  = started_q ? step_q : (head.first ? SL_START : SL_DATA);
	// output register takes a new byte when free or being drained this cycle
	assign load = !oval_q || pop;
	assign emit = load && !qstat.empty;
	assign last = ((cur == SL_DATA) && !head.closing) || (cur == SL_END);
	assign q_pop = emit && last;

	always_comb begin
		byte_d = head.data;
		unique case (cur)
			SL_START:  byte_d = cfg.start_marker;
			SL_TYPE:   byte_d = cfg.frame_type;
			SL_LEN:    byte_d = cfg.payload_length;
			SL_DATA:   byte_d = head.data;
			SL_CRC_HI: byte_d = head.crc[15:8];
			SL_CRC_LO: byte_d = head.crc[7:0];
			SL_END:    byte_d = cfg.end_marker;
			default:   byte_d = head.data;
		endcase
	end

	always_comb begin
		nxt = SL_START;
		unique case (cur)
			SL_START:  nxt = SL_TYPE;
			SL_TYPE:   nxt = SL_LEN;
			SL_LEN:    nxt = SL_DATA;
			SL_DATA:   nxt = SL_CRC_HI;
			SL_CRC_HI: nxt = SL_CRC_LO;
			SL_CRC_LO: nxt = SL_END;
			SL_END:    nxt = SL_START;
			default:   nxt = SL_START;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= SL_START;
			started_q <= 1'b0;
			oval_q    <= 1'b0;
		end else begin
			if (emit) begin
				started_q <= !last;
				step_q    <= nxt;
			end
			if (load) begin
				oval_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q <= byte_d;
			olast_q <= last;
			oend_q  <= (cur == SL_END);
		end
	end

	assign empty      = !oval_q;
	assign frame_byte = obyte_q;
	assign run_last   = olast_q;
	assign frame_end  = oend_q;

endmodule

// File: rtl/crc16_packet_framer.sv
// CRC-16 packet framer.
// Input queue side: push/full with payload_byte; a request is taken when push is high and
// full low. Result queue side: empty/pop with frame_byte, run_last, frame_end; the oldest
// result is shown while empty is low and leaves on pop.
// Each accepted byte yields 1 result (mid-frame), 4 (first or last of a frame, header or
// trailer added) or 7 (a one-byte frame). run_last marks the final result of a request and
// frame_end marks the end marker.
// The first result of a request is written into the input queue and then registered in the
// output register before it is shown. Throughput: one result per cycle while pop is held high,
// set by the single output register; the front takes one byte per cycle while its 4-entry
// queue (QUEUE_DEPTH) has room, the CRC update of a byte being done in that cycle.
// When the receiver stalls the result holds and the queue fills; full then holds off push.
// Reset clears the queue, the output register and the frame position and loads the
// register defaults (markers 0x7E/0x7F, type 0x02, length 69, polynomial 0xA001, initial 0).
// Registers sit at byte address 4*i on the APB port; pready is always high.
`include "crc16_packet_framer_macros.svh"

module crc16_packet_framer #(
	parameter int unsigned QUEUE_DEPTH = cpf_pkg::QueueDepthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpf_pkg::AddrWidth-1:0] paddr,
	input  logic [cpf_pkg::DataWidth-1:0] pwdata,
	output logic [cpf_pkg::DataWidth-1:0] prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    payload_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    frame_byte,
	output logic                          run_last,
	output logic                          frame_end
);
	import cpf_pkg::*;

	cfg_t    cfg;
	ent_t    ent;
	ent_t    head;
	q_stat_t qstat;
	logic    accept;
	logic    q_pop;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	cpf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.payload_byte (payload_byte),
		.ent          (ent)
	);

	cpf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (ent),
		.rd     (q_pop),
		.rdata  (head),
		.stat   (qstat)
	);

	cpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.qstat      (qstat),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.frame_byte (frame_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

	`CPF_ASSERT_NOW(a_end_is_last, !empty && frame_end, run_last, "end marker not last of request")
	`CPF_ASSERT_NOW(a_q_stat, qstat.full, !qstat.empty, "queue full and empty at once")
	`CPF_ASSERT_NOW(a_pop_nonempty, q_pop, !qstat.empty, "queue popped while empty")
	`CPF_ASSERT_NEXT(a_qpop_shows_last, q_pop, !empty && run_last, "request retired without last")

endmodule
